>>> rtl/core/bcci_pkg.sv
`default_nettype none

package bcci_pkg;

    // Curve storage.
    localparam int CURVE_POINTS = 11;
    localparam int PT_IDX_W     = $clog2(CURVE_POINTS);
    localparam int SCAN_CNT_W   = $clog2(CURVE_POINTS + 1);

    // Field widths.
    localparam int VOLT_W  = 13;
    localparam int CAP_W   = 14;
    localparam int PACK_W  = 17;
    localparam int CELLS_W = 5;
    localparam int PCT_W   = 7;
    localparam int IDX_W   = 4;

    // Interpolation arithmetic.
    localparam int MUL_W  = CAP_W + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int NUM_W  = VOLT_W + CAP_W;
    localparam int DEN_W  = VOLT_W + 7;
    localparam int QUOT_W = 8;
    localparam int STEP_W = 5;

    localparam logic [STEP_W-1:0] DIV_LAST_STEP    = STEP_W'(PACK_W - 1);
    localparam logic [STEP_W-1:0] QUOT_LAST_STEP   = STEP_W'(QUOT_W - 1);
    localparam logic [VOLT_W-1:0] FULL_CELL_MV_RST = 13'd4200;
    localparam logic [PCT_W-1:0]  PCT_FULL         = 7'd100;
    localparam logic [DEN_W-1:0]  PCT_SCALE        = 20'd100;

    localparam logic FUNC_ESTIMATE = 1'b0;
    localparam logic FUNC_LOAD     = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_CHECK,
        ST_SCAN,
        ST_MUL0,
        ST_MUL1,
        ST_SUM,
        ST_QUOT,
        ST_FINISH
    } bcci_state_t;

    typedef enum logic [1:0] {
        RES_NONE,
        RES_FULL,
        RES_INTERP
    } bcci_res_sel_t;

    typedef struct packed {
        logic          capture;
        logic          write_point;
        logic          div_step;
        logic          scan_init;
        logic          scan_step;
        logic          mul0;
        logic          mul1;
        logic          sum;
        logic          quot_step;
        logic          out_load;
        bcci_res_sel_t res_sel;
    } bcci_cmd_t;

    typedef struct packed {
        logic step_last;
        logic vcell_full;
        logic scan_hit;
        logic scan_end;
    } bcci_status_t;

endpackage

`default_nettype wire

>>> rtl/core/bcci_dp.sv
`default_nettype none

module bcci_dp (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire bcci_pkg::bcci_cmd_t             cmd,
    output bcci_pkg::bcci_status_t               status,
    input  wire logic                            cfg_write,
    input  wire logic [bcci_pkg::VOLT_W-1:0]     cfg_data,
    input  wire logic [bcci_pkg::IDX_W-1:0]      point_index,
    input  wire logic [bcci_pkg::VOLT_W-1:0]     point_voltage_mv,
    input  wire logic [bcci_pkg::CAP_W-1:0]      point_capacity,
    input  wire logic [bcci_pkg::PACK_W-1:0]     pack_voltage_mv,
    input  wire logic [bcci_pkg::CELLS_W-1:0]    cell_count,
    output logic      [bcci_pkg::PCT_W-1:0]      charge_percent,
    output logic                                 segment_found
);
    import bcci_pkg::*;

    logic [VOLT_W-1:0] curve_voltage_mem [CURVE_POINTS];
    logic [CAP_W-1:0]  curve_capacity_mem [CURVE_POINTS];

    logic [VOLT_W-1:0]     full_cell_mv_reg;
    logic [STEP_W-1:0]     step_cnt_reg;

    // Pack voltage divider.
    logic [PACK_W-1:0]     quo_reg;
    logic [CELLS_W-1:0]    rem_reg;
    logic [CELLS_W-1:0]    cells_reg;
    logic [CELLS_W:0]      div_shift;
    logic                  div_ge;
    logic [CELLS_W:0]      div_diff;
    logic [PACK_W-1:0]     vcell;

    // Curve scan.
    logic [SCAN_CNT_W-1:0] scan_addr_reg;
    logic [PT_IDX_W-1:0]   rd_idx_reg;
    logic [PT_IDX_W-1:0]   rd_addr;
    logic                  rd_en;
    logic [VOLT_W-1:0]     rd_v_reg;
    logic [CAP_W-1:0]      rd_c_reg;
    logic [VOLT_W-1:0]     prev_v_reg;
    logic [CAP_W-1:0]      prev_c_reg;
    logic [VOLT_W-1:0]     seg_v0_reg;
    logic [VOLT_W-1:0]     seg_v1_reg;
    logic [CAP_W-1:0]      seg_c0_reg;
    logic [CAP_W-1:0]      seg_c1_reg;

    // Interpolation.
    logic [VOLT_W-1:0]        dvolt;
    logic [VOLT_W-1:0]        dv;
    logic signed [MUL_W-1:0]  dc;
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] acc_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUM_W-1:0]  sum_w;
    logic [NUM_W-1:0]         num_w;
    logic [DEN_W-1:0]         den_w;
    logic [NUM_W-1:0]         num_rem_reg;
    logic [NUM_W-1:0]         den_sh_reg;
    logic [QUOT_W-1:0]        q_reg;
    logic                     quot_ge;

    logic [PCT_W-1:0] pct_w;
    logic             found_w;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            full_cell_mv_reg <= FULL_CELL_MV_RST;
            step_cnt_reg     <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                full_cell_mv_reg <= cfg_data;
            end
            if (cmd.capture)
            begin
                step_cnt_reg <= DIV_LAST_STEP;
            end
            else if (cmd.sum)
            begin
                step_cnt_reg <= QUOT_LAST_STEP;
            end
            else if (cmd.div_step || cmd.quot_step)
            begin
                step_cnt_reg <= step_cnt_reg - 1'b1;
            end
        end
    end

    // Curve memories.
    always_ff @(posedge clk) begin
        if (cmd.write_point && (32'(point_index) < CURVE_POINTS))
        begin
            curve_voltage_mem[PT_IDX_W'(point_index)]  <= point_voltage_mv;
            curve_capacity_mem[PT_IDX_W'(point_index)] <= point_capacity;
        end
        if (rd_en)
        begin
            rd_v_reg <= curve_voltage_mem[rd_addr];
            rd_c_reg <= curve_capacity_mem[rd_addr];
        end
    end

    assign rd_addr = cmd.scan_init ? '0 : scan_addr_reg[PT_IDX_W-1:0];
    assign rd_en   = cmd.scan_init ||
                     (cmd.scan_step && (32'(scan_addr_reg) < CURVE_POINTS));

    // One quotient bit per step, restoring.
    assign div_shift = {rem_reg, quo_reg[PACK_W-1]};
    assign div_ge    = div_shift >= {1'b0, cells_reg};
    assign div_diff  = div_shift - {1'b0, cells_reg};
    assign vcell     = (cells_reg == '0) ? '0 : quo_reg;

    assign dvolt = seg_v1_reg - seg_v0_reg;
    assign dv    = vcell[VOLT_W-1:0] - seg_v0_reg;
    assign dc    = signed'(MUL_W'(seg_c1_reg)) - signed'(MUL_W'(seg_c0_reg));

    // One shared multiplier: c0*dV first, then dc*dv.
    always_comb begin
        if (cmd.mul1)
        begin
            mul_a = dc;
            mul_b = signed'(MUL_W'(dv));
        end
        else
        begin
            mul_a = signed'(MUL_W'(seg_c0_reg));
            mul_b = signed'(MUL_W'(dvolt));
        end
    end

    assign prod    = mul_a * mul_b;
    assign sum_w   = SUM_W'(acc_reg) + SUM_W'(prod_reg);
    assign num_w   = sum_w[SUM_W-1] ? '0 : sum_w[NUM_W-1:0];
    assign den_w   = DEN_W'(dvolt) * PCT_SCALE;
    assign quot_ge = num_rem_reg >= den_sh_reg;

    always_ff @(posedge clk) begin
        if (cmd.capture)
        begin
            quo_reg   <= pack_voltage_mv;
            rem_reg   <= '0;
            cells_reg <= cell_count;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[PACK_W-2:0], div_ge};
            rem_reg <= div_ge ? div_diff[CELLS_W-1:0] : div_shift[CELLS_W-1:0];
        end

        if (cmd.scan_init)
        begin
            scan_addr_reg <= SCAN_CNT_W'(1);
            rd_idx_reg    <= '0;
        end
        else if (cmd.scan_step)
        begin
            scan_addr_reg <= scan_addr_reg + 1'b1;
            rd_idx_reg    <= scan_addr_reg[PT_IDX_W-1:0];
            prev_v_reg    <= rd_v_reg;
            prev_c_reg    <= rd_c_reg;
        end

        if (cmd.scan_step && status.scan_hit)
        begin
            seg_v0_reg <= prev_v_reg;
            seg_v1_reg <= rd_v_reg;
            seg_c0_reg <= prev_c_reg;
            seg_c1_reg <= rd_c_reg;
        end

        if (cmd.mul0)
        begin
            acc_reg <= prod;
        end
        if (cmd.mul1)
        begin
            prod_reg <= prod;
        end

        // The quotient is known to stay below 256, so eight steps suffice.
        if (cmd.sum)
        begin
            num_rem_reg <= num_w;
            den_sh_reg  <= NUM_W'(den_w) << (QUOT_W - 1);
            q_reg       <= '0;
        end
        else if (cmd.quot_step)
        begin
            if (quot_ge)
            begin
                num_rem_reg <= num_rem_reg - den_sh_reg;
            end
            den_sh_reg <= den_sh_reg >> 1;
            q_reg      <= {q_reg[QUOT_W-2:0], quot_ge};
        end

        if (cmd.out_load)
        begin
            charge_percent <= pct_w;
            segment_found  <= found_w;
        end
    end

    always_comb begin
        case (cmd.res_sel)
            RES_FULL:
            begin
                pct_w   = PCT_FULL;
                found_w = 1'b1;
            end
            RES_INTERP:
            begin
                pct_w   = (q_reg > QUOT_W'(PCT_FULL)) ? PCT_FULL : q_reg[PCT_W-1:0];
                found_w = 1'b1;
            end
            default:
            begin
                pct_w   = '0;
                found_w = 1'b0;
            end
        endcase
    end

    assign status.step_last  = step_cnt_reg == '0;
    assign status.vcell_full = vcell >= PACK_W'(full_cell_mv_reg);
    assign status.scan_hit   = (rd_idx_reg != '0) &&
                               (vcell > PACK_W'(prev_v_reg)) &&
                               (vcell <= PACK_W'(rd_v_reg));
    assign status.scan_end   = rd_idx_reg == PT_IDX_W'(CURVE_POINTS - 1);

endmodule

`default_nettype wire

>>> rtl/core/bcci_ctrl.sv
`default_nettype none

module bcci_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   item_valid,
    input  wire logic                   func,
    output logic                        item_stall,
    output logic                        result_valid,
    input  wire logic                   result_stall,
    input  wire bcci_pkg::bcci_status_t status,
    output bcci_pkg::bcci_cmd_t         cmd
);
    import bcci_pkg::*;

    bcci_state_t   state_reg;
    bcci_state_t   state_next;
    bcci_res_sel_t res_sel_reg;
    bcci_res_sel_t res_sel_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          out_free;

    // The output register can take a new result once the old one leaves.
    assign out_free     = !out_valid_reg || !result_stall;
    assign item_stall   = state_reg != ST_IDLE;
    assign result_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_sel_reg   <= RES_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_sel_reg   <= res_sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        res_sel_next   = res_sel_reg;
        out_valid_next = out_valid_reg && result_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (func == FUNC_LOAD)
                    begin
                        res_sel_next = RES_NONE;
                        state_next   = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_DIVIDE;
                    end
                end
            end
            ST_DIVIDE:
            begin
                if (status.step_last)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.vcell_full)
                begin
                    res_sel_next = RES_FULL;
                    state_next   = ST_FINISH;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_hit)
                begin
                    state_next = ST_MUL0;
                end
                else if (status.scan_end)
                begin
                    res_sel_next = RES_NONE;
                    state_next   = ST_FINISH;
                end
            end
            ST_MUL0:
            begin
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                state_next = ST_QUOT;
            end
            ST_QUOT:
            begin
                if (status.step_last)
                begin
                    res_sel_next = RES_INTERP;
                    state_next   = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd         = '0;
        cmd.res_sel = res_sel_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.write_point = item_valid && (func == FUNC_LOAD);
                cmd.capture     = item_valid && (func == FUNC_ESTIMATE);
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
            end
            ST_CHECK:
            begin
                cmd.scan_init = !status.vcell_full;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            ST_MUL0:
            begin
                cmd.mul0 = 1'b1;
            end
            ST_MUL1:
            begin
                cmd.mul1 = 1'b1;
            end
            ST_SUM:
            begin
                cmd.sum = 1'b1;
            end
            ST_QUOT:
            begin
                cmd.quot_step = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                cmd.res_sel = RES_NONE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/battery_charge_curve_interp_top.sv
`default_nettype none

// Channel   Handshake                   Payload
// item      item_valid / item_stall     func, point_index, point_voltage_mv,
//                                       point_capacity, pack_voltage_mv, cell_count
// result    result_valid / result_stall charge_percent, segment_found
// config    cfg_write                   cfg_data (full_cell_mv)
//
// A load item writes its point on acceptance and still returns a result, with segment_found low.
// The 17-step serial pack divider, the curve scan at one point per memory read,
// and the 8-step percent divider set the estimate time.
// One item is worked on at a time; a new item is taken while a result waits.
// Reset clears the control and sets full_cell_mv to 4200; curve points hold
// nothing until loaded.

module battery_charge_curve_interp_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [bcci_pkg::VOLT_W-1:0]     cfg_data,
    input  wire logic                            item_valid,
    output logic                                 item_stall,
    input  wire logic                            func,
    input  wire logic [bcci_pkg::IDX_W-1:0]      point_index,
    input  wire logic [bcci_pkg::VOLT_W-1:0]     point_voltage_mv,
    input  wire logic [bcci_pkg::CAP_W-1:0]      point_capacity,
    input  wire logic [bcci_pkg::PACK_W-1:0]     pack_voltage_mv,
    input  wire logic [bcci_pkg::CELLS_W-1:0]    cell_count,
    output logic                                 result_valid,
    input  wire logic                            result_stall,
    output logic      [bcci_pkg::PCT_W-1:0]      charge_percent,
    output logic                                 segment_found
);
    import bcci_pkg::*;

    bcci_cmd_t    cmd;
    bcci_status_t status;

    bcci_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .func         (func),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    bcci_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .cfg_write        (cfg_write),
        .cfg_data         (cfg_data),
        .point_index      (point_index),
        .point_voltage_mv (point_voltage_mv),
        .point_capacity   (point_capacity),
        .pack_voltage_mv  (pack_voltage_mv),
        .cell_count       (cell_count),
        .charge_percent   (charge_percent),
        .segment_found    (segment_found)
    );

endmodule

`default_nettype wire
